// File: sv/ofdmbi_pkg.sv
// Shared types, constants and lane functions for the OFDM bit interleaver.
// No dependencies; every other file of the block refers to this package.
package ofdmbi_pkg;

	localparam int unsigned LANES          = 6;
	localparam int unsigned BPS_W          = 3;
	localparam int unsigned BLOCK_SIZE_DEF = 126;

	typedef logic [LANES-1:0] lanes_t;
	typedef logic [BPS_W-1:0] bps_t;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam bps_t BPS_QAM64 = 3'd6;
	localparam bps_t BPS_QAM16 = 3'd4;
	localparam bps_t BPS_RESET = 3'd2;

	// read offset of each interleaved lane within the block
	localparam int unsigned LANE_OFFSET [LANES] = '{0, 63, 105, 42, 21, 84};

	// lanes in use for a constellation setting
	function automatic lanes_t lane_mask(input bps_t bps);
		lanes_t m;
		case (bps)
			BPS_QAM64: m = 6'b111111;
			BPS_QAM16: m = 6'b001111;
			default:   m = 6'b000011;
		endcase
		return m;
	endfunction

	// demultiplex one group of stream bits onto the bit lanes
	function automatic lanes_t split_group(input bps_t bps, input lanes_t bits);
		lanes_t l;
		l = '0;
		case (bps)
			BPS_QAM64: begin
				l[0] = bits[0];
				l[2] = bits[1];
				l[4] = bits[2];
				l[1] = bits[3];
				l[3] = bits[4];
				l[5] = bits[5];
			end
			BPS_QAM16: begin
				l[0] = bits[0];
				l[2] = bits[1];
				l[1] = bits[2];
				l[3] = bits[3];
			end
			default: begin
				l[1:0] = bits[1:0];
			end
		endcase
		return l;
	endfunction

endpackage

// File: sv/ofdmbi_ifs.sv
// Valid/ready channel interfaces for the OFDM bit interleaver: items, results
// and the configuration write channel. Depends on ofdmbi_pkg.
interface ofdmbi_item_if;
	logic                 valid;
	logic                 ready;
	logic                 command;
	ofdmbi_pkg::lanes_t   in_bits;

	modport source (output valid, output command, output in_bits, input ready);
	modport sink   (input valid, input command, input in_bits, output ready);
endinterface

interface ofdmbi_result_if;
	logic                 valid;
	logic                 ready;
	ofdmbi_pkg::lanes_t   out_bits;
	logic                 last_in_block;

	modport source (output valid, output out_bits, output last_in_block, input ready);
	modport sink   (input valid, input out_bits, input last_in_block, output ready);
endinterface

interface ofdmbi_cfg_if;
	logic                 valid;
	logic                 ready;
	ofdmbi_pkg::bps_t     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ofdm_bit_interleaver.sv
// OFDM inner bit interleaver: lane split, double-banked block store, offset read-out.
// A word read on an item transfer passes through stage 1 and the output register to result_ch.
// Throughput: one item per cycle unless result_ch stalls; each lane column takes one write and one read a cycle.
// Reset (arst_n low): nothing pending, position 0, bank 0, bits_per_symbol 2.
// The store itself is not cleared; only fully written banks are ever read.
// Depends on ofdmbi_pkg and the channel interfaces in ofdmbi_ifs.sv.
module ofdm_bit_interleaver #(
	parameter int unsigned BLOCK_SIZE = ofdmbi_pkg::BLOCK_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	ofdmbi_item_if.sink              item_ch,
	ofdmbi_result_if.source          result_ch,
	ofdmbi_cfg_if.sink               cfg_ch
);

	localparam int unsigned PW = $clog2(BLOCK_SIZE);
	localparam logic [PW:0]   BLOCK_LIM = (PW+1)'(BLOCK_SIZE);
	localparam logic [PW-1:0] LAST_POS  = PW'(BLOCK_SIZE - 1);

	// ---------------------------------------------------------------
	// Configuration register: always ready; write it only while idle (the block does not enforce this).
	// ---------------------------------------------------------------
	ofdmbi_pkg::bps_t bps_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q <= ofdmbi_pkg::BPS_RESET;
		end else if (cfg_ch.valid) begin
			bps_q <= cfg_ch.data;
		end
	end

	// ---------------------------------------------------------------
	// Block control: position doubles as load slot and read word.
	// ---------------------------------------------------------------
	logic [PW-1:0] pos_q;
	logic          wbank_q;
	logic          pending_q;

	logic          valid_s1;
	logic          last_s1;
	ofdmbi_pkg::lanes_t mask_s1;
	ofdmbi_pkg::lanes_t rd_s1;

	logic          out_valid_q;
	ofdmbi_pkg::lanes_t out_bits_q;
	logic          out_last_q;

	logic          advance;
	logic          accept;
	logic          is_flush;
	logic          do_write;
	logic          do_read;
	logic          at_last;
	ofdmbi_pkg::lanes_t split_lanes;

	// The output register frees up when it is empty or its word is taken;
	// stage 1 frees up when it is empty or moves into the output register.
	assign advance       = !out_valid_q || result_ch.ready;
	assign item_ch.ready = !valid_s1 || advance;
	assign accept        = item_ch.valid && item_ch.ready;

	assign is_flush    = (item_ch.command == ofdmbi_pkg::CMD_FLUSH);
	assign do_write    = accept && !is_flush;
	assign do_read     = accept && pending_q;
	assign at_last     = (pos_q == LAST_POS);
	assign split_lanes = ofdmbi_pkg::split_group(bps_q, item_ch.in_bits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wbank_q   <= 1'b0;
			pending_q <= 1'b0;
		end else if (accept) begin
			if (!is_flush) begin
				// load one slot; a full bank swaps over and becomes pending
				if (at_last) begin
					pos_q     <= '0;
					wbank_q   <= ~wbank_q;
					pending_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (pending_q) begin
				// drain one word; abandon any partial load at the end
				if (at_last) begin
					pos_q     <= '0;
					pending_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Lane store: one bit column per lane, two banks of BLOCK_SIZE.
	// Each column is written at the load slot and read at its own offset
	// in the other bank, so reads and writes never meet on one entry.
	// ---------------------------------------------------------------
	for (genvar e = 0; e < ofdmbi_pkg::LANES; e++) begin : g_lane
		localparam logic [PW:0] OFF = (PW+1)'(ofdmbi_pkg::LANE_OFFSET[e]);

		logic          lane_mem_q [2][BLOCK_SIZE];
		logic [PW:0]   sum;
		logic [PW-1:0] raddr;
		logic          rd_bit_s1;

		// offset is below the block size, so one subtract wraps the sum
		assign sum   = {1'b0, pos_q} + OFF;
		assign raddr = (sum >= BLOCK_LIM) ? PW'(sum - BLOCK_LIM) : sum[PW-1:0];

		always_ff @(posedge clk) begin
			if (do_write) begin
				lane_mem_q[wbank_q][pos_q] <= split_lanes[e];
			end
			if (do_read) begin
				rd_bit_s1 <= lane_mem_q[~wbank_q][raddr];
			end
		end

		assign rd_s1[e] = rd_bit_s1;
	end

	// ---------------------------------------------------------------
	// Stage 1 control: lane mask and last flag travel with the read.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (do_read) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			last_s1 <= at_last;
			mask_s1 <= ofdmbi_pkg::lane_mask(bps_q);
		end
	end

	// ---------------------------------------------------------------
	// Output register: hold the word until the transfer completes.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_bits_q <= rd_s1 & mask_s1;
			out_last_q <= last_s1;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.out_bits      = out_bits_q;
	assign result_ch.last_in_block = out_last_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	// a block only becomes pending through a bank swap
	a_pending_swap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> (wbank_q != $past(wbank_q)))
		else $error("block became pending without a bank swap");

	// a bank swap always leaves a block pending
	a_swap_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(wbank_q != $past(wbank_q)) |-> pending_q)
		else $error("bank swap without a pending block");

	// a word reaches the output only from a filled stage 1
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("output word appeared without a stage 1 read");

	// reading the last word of a block returns position to zero
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(do_read && at_last) |=> (pos_q == '0))
		else $error("position did not wrap after the last word");

endmodule

// File: tb/tb.sv
// Self-checking bench for ofdm_bit_interleaver: a directed table, then random phases.
// A local predictor of the lane split and offset read-out checks every word.
// Depends on ofdmbi_pkg, the channel interfaces in ofdmbi_ifs.sv and the block itself.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned BLK          = ofdmbi_pkg::BLOCK_SIZE_DEF;
	localparam int unsigned ITEM_TOTAL   = 1650;     // items sent, directed and random
	localparam int unsigned SETTLE       = 8;        // cycles of quiet before a register write
	localparam int unsigned DRAIN        = 20;       // cycles watched for stray words at the end
	localparam longint     CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned PLAN_ROWS    = 17;

	// settings that fall back to QPSK
	localparam ofdmbi_pkg::bps_t BPS_ALL_ONES = 3'd7;
	localparam ofdmbi_pkg::bps_t BPS_ALL_ZERO = 3'd0;

	// read offsets of the interleaved lanes, lane 0 first
	localparam int unsigned READ_OFS [ofdmbi_pkg::LANES] = '{0, 63, 105, 42, 21, 84};

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic               cmd;
		ofdmbi_pkg::lanes_t bits;
		int                 reps;
		bit                 typed;   // word value written into the row
		ofdmbi_pkg::lanes_t want;
		ofdmbi_pkg::bps_t   bps;
	} plan_row_t;

	typedef struct {
		ofdmbi_pkg::lanes_t bits;
		logic               last;
	} word_t;

	logic clk;
	logic arst_n;

	ofdmbi_item_if   item_ch ();
	ofdmbi_result_if result_ch ();
	ofdmbi_cfg_if    cfg_ch ();

	ofdm_bit_interleaver #(
		.BLOCK_SIZE (BLK)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (item_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	// ---------------------------------------------------------------
	// Clock, 4 ns period
	// ---------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor state: two banks, the shared load/read position,
	// the bank being loaded and whether the other bank holds a block.
	// ---------------------------------------------------------------
	ofdmbi_pkg::lanes_t bank_mem [2][BLK];
	int unsigned        slot_pos;
	bit                 load_bank;
	bit                 have_block;
	ofdmbi_pkg::bps_t   model_bps;

	word_t       pending_words [$];
	int unsigned fail_count;
	int unsigned words_checked;
	int unsigned cfg_writes;
	int unsigned items_sent;
	longint      cycle_count;
	bit          calm;          // set for stretches with no idling on either side

	function automatic int unsigned lanes_in_use(input ofdmbi_pkg::bps_t b);
		if (b == ofdmbi_pkg::BPS_QAM64)
			return 6;
		if (b == ofdmbi_pkg::BPS_QAM16)
			return 4;
		return 2;
	endfunction

	// The first half of the group lands on the even lanes, the second half on the
	// odd ones; with two lanes this collapses to straight through.
	function automatic ofdmbi_pkg::lanes_t demux_group(input ofdmbi_pkg::bps_t b,
			input ofdmbi_pkg::lanes_t g);
		int unsigned        n;
		int unsigned        half;
		int unsigned        dest;
		ofdmbi_pkg::lanes_t l;
		n = lanes_in_use(b);
		half = n / 2;
		l = '0;
		for (int unsigned j = 0; j < n; j++) begin
			dest = (j < half) ? 2 * j : 2 * (j - half) + 1;
			l[dest] = g[j];
		end
		return l;
	endfunction

	// Gather one word from the bank that is not being loaded.
	function automatic ofdmbi_pkg::lanes_t gather_word();
		int unsigned        n;
		int unsigned        slot;
		ofdmbi_pkg::lanes_t w;
		n = lanes_in_use(model_bps);
		w = '0;
		for (int unsigned e = 0; e < n; e++) begin
			slot = (slot_pos + READ_OFS[e]) % BLK;
			w[e] = bank_mem[~load_bank][slot][e];
		end
		return w;
	endfunction

	// Advance the predictor by one accepted item. A flush with nothing pending
	// leaves the state untouched.
	task automatic interleave_step(input logic cmd, input ofdmbi_pkg::lanes_t g,
			output bit emitted, output word_t w);
		emitted = 1'b0;
		w.bits  = '0;
		w.last  = 1'b0;
		if (cmd == ofdmbi_pkg::CMD_FLUSH) begin
			if (have_block) begin
				emitted = 1'b1;
				w.bits  = gather_word();
				w.last  = (slot_pos == BLK - 1);
				if (w.last) begin
					// drained: abandon whatever was loaded since the swap
					slot_pos   = 0;
					have_block = 1'b0;
				end else begin
					slot_pos++;
				end
			end
		end else begin
			if (have_block) begin
				emitted = 1'b1;
				w.bits  = gather_word();
				w.last  = (slot_pos == BLK - 1);
			end
			bank_mem[load_bank][slot_pos] = demux_group(model_bps, g);
			if (slot_pos == BLK - 1) begin
				slot_pos   = 0;
				load_bank  = ~load_bank;
				have_block = 1'b1;
			end else begin
				slot_pos++;
			end
		end
	endtask

	// Mostly back to back, sometimes a short pause, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ---------------------------------------------------------------
	// Item source. Called at a rising edge; returns at the edge of the transfer,
	// so that a following item can be driven in the same step.
	// ---------------------------------------------------------------
	task automatic send_item(input logic cmd, input ofdmbi_pkg::lanes_t g, input bit typed,
			input ofdmbi_pkg::lanes_t want);
		int unsigned gap;
		bit          emitted;
		word_t       w;
		gap = gap_len();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.command <= cmd;
		item_ch.in_bits <= g;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		interleave_step(cmd, g, emitted, w);
		if (emitted) begin
			// a typed row overrides the word value, the predictor still gives the flag
			if (typed)
				w.bits = want;
			pending_words.push_back(w);
		end
		items_sent++;
	endtask

	// Register write, only once the block has gone quiet.
	task automatic write_bps(input ofdmbi_pkg::bps_t v);
		item_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		// pushes with nothing pending leave no word behind; let them settle
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		model_bps = v;
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
	endtask

	function automatic void report_fail(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0d] %s", cycle_count, what);
	endfunction

	// ---------------------------------------------------------------
	// Result sink: random back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin : rx_stall
		int unsigned g;
		int unsigned hold;
		if (hold > 0) begin
			hold = hold - 1;
			result_ch.ready <= 1'b0;
		end else begin
			g = gap_len();
			if (g == 0) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b0;
				hold = g - 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Word checker: compare every transfer with the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin : word_check
		word_t w;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_words.size() == 0) begin
				report_fail($sformatf("unexpected word out_bits=%h last=%b",
					result_ch.out_bits, result_ch.last_in_block));
			end else begin
				w = pending_words.pop_front();
				words_checked++;
				if (result_ch.out_bits !== w.bits || result_ch.last_in_block !== w.last)
					report_fail($sformatf("word %0d: want out_bits=%h last=%b, got %h %b",
						words_checked, w.bits, w.last,
						result_ch.out_bits, result_ch.last_in_block));
			end
		end
	end

	// ---------------------------------------------------------------
	// Cycle count, calm stretches and the watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if ($urandom_range(0, 299) == 0)
			calm = ~calm;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due",
				cycle_count, pending_words.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Directed plan. Typed word values are only those that can be read off at a
	// glance: a uniform block reads back as its stored lanes under the read mask,
	// whatever the offsets. After a setting change, any block left pending reads out under the new setting.
	// ---------------------------------------------------------------
	plan_row_t plan [PLAN_ROWS];

	initial begin : stimulus
		int unsigned        flush_pct;
		int unsigned        phase_len;
		int unsigned        r;
		int unsigned        phases;
		logic               cmd;
		ofdmbi_pkg::lanes_t g;
		ofdmbi_pkg::bps_t   v;

		plan = '{
			// flush straight after reset: nothing pending, ignored
			'{ROW_ITEM, ofdmbi_pkg::CMD_FLUSH, 6'h3F, 1,   1'b0, 6'h00, ofdmbi_pkg::BPS_RESET},
			// QPSK at reset: fill with ones, then push zeros while it reads out
			'{ROW_ITEM, ofdmbi_pkg::CMD_PUSH,  6'h3F, BLK, 1'b0, 6'h00, ofdmbi_pkg::BPS_RESET},
			'{ROW_ITEM, ofdmbi_pkg::CMD_PUSH,  6'h00, BLK, 1'b1, 6'h03, ofdmbi_pkg::BPS_RESET},
			// 64QAM: the pending zero block reads as zero, all lanes load
			'{ROW_CFG,  ofdmbi_pkg::CMD_PUSH,  6'h00, 0,   1'b0, 6'h00, ofdmbi_pkg::BPS_QAM64},
			'{ROW_ITEM, ofdmbi_pkg::CMD_PUSH,  6'h3F, BLK, 1'b1, 6'h00, ofdmbi_pkg::BPS_QAM64},
			// 16QAM: the full 64QAM block reads through the narrower mask
			'{ROW_CFG,  ofdmbi_pkg::CMD_PUSH,  6'h00, 0,   1'b0, 6'h00, ofdmbi_pkg::BPS_QAM16},
			'{ROW_ITEM, ofdmbi_pkg::CMD_PUSH,  6'h3F, BLK, 1'b1, 6'h0F, ofdmbi_pkg::BPS_QAM16},
			// top setting value falls back to QPSK
			'{ROW_CFG,  ofdmbi_pkg::CMD_PUSH,  6'h00, 0,   1'b0, 6'h00, BPS_ALL_ONES},
			'{ROW_ITEM, ofdmbi_pkg::CMD_PUSH,  6'h3F, BLK, 1'b1, 6'h03, BPS_ALL_ONES},
			// loaded as QPSK, read as 64QAM: the lanes never filled read as zero
			'{ROW_CFG,  ofdmbi_pkg::CMD_PUSH,  6'h00, 0,   1'b0, 6'h00, ofdmbi_pkg::BPS_QAM64},
			'{ROW_ITEM, ofdmbi_pkg::CMD_PUSH,  6'h3F, 40,  1'b1, 6'h03, ofdmbi_pkg::BPS_QAM64},
			// zero setting; flushing drains the block and abandons the partial one
			'{ROW_CFG,  ofdmbi_pkg::CMD_PUSH,  6'h00, 0,   1'b0, 6'h00, BPS_ALL_ZERO},
			'{ROW_ITEM, ofdmbi_pkg::CMD_FLUSH, 6'h3F, BLK - 40, 1'b1, 6'h03, BPS_ALL_ZERO},
			// drained: further flushes are ignored
			'{ROW_ITEM, ofdmbi_pkg::CMD_FLUSH, 6'h3F, 2,   1'b0, 6'h00, BPS_ALL_ZERO},
			// a fixed group spread over the lanes, checked against the predictor
			'{ROW_CFG,  ofdmbi_pkg::CMD_PUSH,  6'h00, 0,   1'b0, 6'h00, ofdmbi_pkg::BPS_QAM64},
			'{ROW_ITEM, ofdmbi_pkg::CMD_PUSH,  6'h15, BLK, 1'b0, 6'h00, ofdmbi_pkg::BPS_QAM64},
			'{ROW_ITEM, ofdmbi_pkg::CMD_FLUSH, 6'h00, BLK, 1'b0, 6'h00, ofdmbi_pkg::BPS_QAM64}
		};

		// predictor after reset; the store itself starts undefined and is never
		// read before a full bank has been written
		for (int b = 0; b < 2; b++)
			for (int s = 0; s < BLK; s++)
				bank_mem[b][s] = '0;
		slot_pos      = 0;
		load_bank     = 1'b0;
		have_block    = 1'b0;
		model_bps     = ofdmbi_pkg::BPS_RESET;
		fail_count    = 0;
		words_checked = 0;
		cfg_writes    = 0;
		items_sent    = 0;
		cycle_count   = 0;
		calm          = 1'b0;
		phases        = 0;

		// drive every input to a known level before the first edge
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.command = ofdmbi_pkg::CMD_PUSH;
		item_ch.in_bits = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = ofdmbi_pkg::BPS_RESET;
		result_ch.ready = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_bps(plan[i].bps);
			end else begin
				for (int k = 0; k < plan[i].reps; k++)
					send_item(plan[i].cmd, plan[i].bits, plan[i].typed, plan[i].want);
			end
		end

		// random phases: pick a setting, then a run of pushes with a share of flushes
		// (from none up to 60 percent), until the item total is reached
		while (items_sent < ITEM_TOTAL) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				v = ofdmbi_pkg::BPS_QAM64;
			else if (r < 55)
				v = ofdmbi_pkg::BPS_QAM16;
			else if (r < 75)
				v = ofdmbi_pkg::BPS_RESET;
			else
				v = ofdmbi_pkg::bps_t'($urandom_range(0, 7));
			write_bps(v);
			phases++;

			phase_len = $urandom_range(60, 300);
			r = $urandom_range(0, 9);
			if (r < 4)
				flush_pct = 0;
			else if (r < 7)
				flush_pct = 5;
			else if (r < 9)
				flush_pct = 20;
			else
				flush_pct = 60;

			for (int k = 0; k < phase_len && items_sent < ITEM_TOTAL; k++) begin
				cmd = ($urandom_range(0, 99) < flush_pct) ? ofdmbi_pkg::CMD_FLUSH
					: ofdmbi_pkg::CMD_PUSH;
				r = $urandom_range(0, 9);
				if (r == 0)
					g = '0;
				else if (r == 1)
					g = '1;
				else
					g = ofdmbi_pkg::lanes_t'($urandom_range(0, 63));
				send_item(cmd, g, 1'b0, '0);
			end
		end

		// wind down: hold valid low, wait for the last words, then watch for strays
		item_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (pending_words.size() != 0)
			report_fail($sformatf("%0d words never arrived", pending_words.size()));

		$display("covered %0d items in %0d random phases, %0d register writes",
			items_sent, phases, cfg_writes);
		$display("checked %0d words in %0d cycles, %0d failures",
			words_checked, cycle_count, fail_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
